// ===== rtl/core/value_noise_2d_macros.svh =====
// Assertion helpers for the value noise block.
`ifndef VALUE_NOISE_2D_MACROS_SVH
`define VALUE_NOISE_2D_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define VN2D_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define VN2D_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/vn2d_pkg.sv =====
package vn2d_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int COORD_W    = 32;
    localparam int NOISE_W    = 18;
    localparam int OUT_SHIFT  = 14;

    // Pipeline depth: five stages for hash and easing, four for the blend.
    localparam int FRONT_STAGES = 5;
    localparam int BLEND_STAGES = 4;
    localparam int NUM_STAGES   = FRONT_STAGES + BLEND_STAGES;

    // Integer hash constants.
    localparam logic [31:0] HASH_ROW   = 32'd57;
    localparam int          HASH_SHIFT = 13;
    localparam logic [31:0] HASH_MUL_A = 32'd15731;
    localparam logic [31:0] HASH_ADD_B = 32'd789221;
    localparam logic [31:0] HASH_ADD_C = 32'd1376312589;
    localparam logic [31:0] HASH_MASK  = 32'h7fff_ffff;
    localparam logic [31:0] CORNER_ONE = 32'h4000_0000;

    // One in Q1.FRAC_BITS, and three in Q2.FRAC_BITS.
    localparam logic [FRAC_BITS:0]   SCALE       = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [FRAC_BITS+1:0] THREE_SCALE = {2'b11, {FRAC_BITS{1'b0}}};

    typedef logic [NUM_STAGES-1:0]  stage_adv_t;
    typedef logic [31:0]            lattice_t;
    typedef logic signed [31:0]     corner_t;
    typedef logic [FRAC_BITS-1:0]   frac_t;

endpackage

// ===== rtl/core/vn2d_hash.sv =====
module vn2d_hash (
    input  logic                 clk,
    input  vn2d_pkg::stage_adv_t adv,
    input  vn2d_pkg::lattice_t   ix,
    input  vn2d_pkg::lattice_t   iy,
    output vn2d_pkg::corner_t    corner
);
    import vn2d_pkg::*;

    logic [31:0] seed;
    logic [31:0] mix_next;
    logic [31:0] val;
    logic [31:0] h1_reg;
    logic [31:0] h2_reg;
    logic [31:0] sq_reg;
    logic [31:0] h3_reg;
    logic [31:0] poly_reg;
    logic [31:0] prod_reg;
    corner_t     corner_reg;

    assign seed     = ix + iy * HASH_ROW;
    assign mix_next = seed ^ (seed << HASH_SHIFT);
    assign val      = (prod_reg + HASH_ADD_C) & HASH_MASK;

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            h1_reg <= mix_next;
        end
        if (adv[1])
        begin
            h2_reg <= h1_reg;
            sq_reg <= h1_reg * h1_reg;
        end
        if (adv[2])
        begin
            h3_reg   <= h2_reg;
            poly_reg <= sq_reg * HASH_MUL_A + HASH_ADD_B;
        end
        if (adv[3])
        begin
            prod_reg <= h3_reg * poly_reg;
        end
        if (adv[4])
        begin
            corner_reg <= $signed(CORNER_ONE - val);
        end
    end

    assign corner = corner_reg;

endmodule

// ===== rtl/core/vn2d_ease.sv =====
module vn2d_ease (
    input  logic                 clk,
    input  vn2d_pkg::stage_adv_t adv,
    input  vn2d_pkg::frac_t      frac,
    output vn2d_pkg::frac_t      eased
);
    import vn2d_pkg::*;

    logic [2*FRAC_BITS-1:0] ff_reg;
    frac_t                  f_reg;
    logic [FRAC_BITS+1:0]   slope;
    logic [2*FRAC_BITS+1:0] m_reg;
    frac_t                  u3_reg;
    frac_t                  u4_reg;
    frac_t                  u5_reg;

    // 3 - 2f in Q2.FRAC_BITS, always positive.
    assign slope = THREE_SCALE - {1'b0, f_reg, 1'b0};

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            f_reg  <= frac;
            ff_reg <= frac * frac;
        end
        if (adv[1])
        begin
            m_reg <= ff_reg[2*FRAC_BITS-1:FRAC_BITS] * slope;
        end
        if (adv[2])
        begin
            // The eased value stays below one.
            u3_reg <= m_reg[2*FRAC_BITS-1:FRAC_BITS];
        end
        if (adv[3])
        begin
            u4_reg <= u3_reg;
        end
        if (adv[4])
        begin
            u5_reg <= u4_reg;
        end
    end

    assign eased = u5_reg;

endmodule

// ===== rtl/core/vn2d_blend.sv =====
module vn2d_blend (
    input  logic                         clk,
    input  vn2d_pkg::stage_adv_t         adv,
    input  vn2d_pkg::corner_t            ca,
    input  vn2d_pkg::corner_t            cb,
    input  vn2d_pkg::corner_t            cc,
    input  vn2d_pkg::corner_t            cd,
    input  vn2d_pkg::frac_t              ux,
    input  vn2d_pkg::frac_t              uy,
    output logic signed [vn2d_pkg::NOISE_W-1:0] noise
);
    import vn2d_pkg::*;

    localparam int WW = FRAC_BITS + 2;
    localparam int PW = 32 + WW;
    localparam int S0 = FRONT_STAGES;

    logic signed [WW-1:0] wx0;
    logic signed [WW-1:0] wx1;
    logic signed [WW-1:0] wy0;
    logic signed [WW-1:0] wy1;
    logic signed [PW-1:0] pa_reg;
    logic signed [PW-1:0] pb_reg;
    logic signed [PW-1:0] pc_reg;
    logic signed [PW-1:0] pd_reg;
    frac_t                uy6_reg;
    frac_t                uy7_reg;
    logic signed [PW:0]   sum_top;
    logic signed [PW:0]   sum_bot;
    logic signed [PW:0]   sh_top;
    logic signed [PW:0]   sh_bot;
    corner_t              top_reg;
    corner_t              bot_reg;
    logic signed [PW-1:0] pt_reg;
    logic signed [PW-1:0] pu_reg;
    logic signed [PW:0]   sum_r;
    logic signed [PW:0]   sh_r;
    logic signed [NOISE_W-1:0] noise_reg;

    assign wx0 = $signed({1'b0, SCALE - {1'b0, ux}});
    assign wx1 = $signed({2'b00, ux});
    assign wy0 = $signed({1'b0, SCALE - {1'b0, uy7_reg}});
    assign wy1 = $signed({2'b00, uy7_reg});

    assign sum_top = pa_reg + pb_reg;
    assign sum_bot = pc_reg + pd_reg;
    assign sh_top  = sum_top >>> FRAC_BITS;
    assign sh_bot  = sum_bot >>> FRAC_BITS;
    assign sum_r   = pt_reg + pu_reg;
    assign sh_r    = sum_r >>> FRAC_BITS;

    always_ff @(posedge clk)
    begin
        if (adv[S0])
        begin
            pa_reg  <= ca * wx0;
            pb_reg  <= cb * wx1;
            pc_reg  <= cc * wx0;
            pd_reg  <= cd * wx1;
            uy6_reg <= uy;
        end
        if (adv[S0+1])
        begin
            // Blends are convex: results fit Q2.30.
            top_reg <= sh_top[31:0];
            bot_reg <= sh_bot[31:0];
            uy7_reg <= uy6_reg;
        end
        if (adv[S0+2])
        begin
            pt_reg <= top_reg * wy0;
            pu_reg <= bot_reg * wy1;
        end
        if (adv[S0+3])
        begin
            noise_reg <= sh_r[31:OUT_SHIFT];
        end
    end

    assign noise = noise_reg;

endmodule

// ===== rtl/core/value_noise_2d.sv =====
// Channel  | Handshake            | Payload
// ---------+----------------------+------------------------------------
// input    | in_valid / in_ready  | coord_x, coord_y (Q15.16, signed)
// output   | out_valid / out_ready| noise_value (Q1.16, signed, +/-1)
//
// Nine register stages; one transfer per cycle in and out while the output is not stalled.
// The 32x32 hash multiplies (square, then product with the polynomial) and the
// blend multiplies each own a stage, which sets the depth.
// Reset clears only the stage valid bits; data registers are not reset.
// Each stage loads when it is empty or the stage after it advances, so a stall
// at the output fills bubbles first and holds every item in place.
module value_noise_2d (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [vn2d_pkg::COORD_W-1:0] coord_x,
    input  logic signed [vn2d_pkg::COORD_W-1:0] coord_y,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [vn2d_pkg::NOISE_W-1:0] noise_value
);
    import vn2d_pkg::*;

`include "value_noise_2d_macros.svh"

    stage_adv_t adv;
    stage_adv_t valid_reg;
    stage_adv_t valid_next;

    lattice_t ix;
    lattice_t iy;
    lattice_t ix1;
    lattice_t iy1;
    frac_t    fx;
    frac_t    fy;
    frac_t    ux;
    frac_t    uy;
    corner_t  ca;
    corner_t  cb;
    corner_t  cc;
    corner_t  cd;

    // Advance chain: a stage moves when empty or when its successor moves.
    always_comb
    begin
        adv[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || out_ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--)
        begin
            adv[k] = !valid_reg[k] || adv[k+1];
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (adv[0])
        begin
            valid_next[0] = in_valid;
        end
        for (int k = 1; k < NUM_STAGES; k++)
        begin
            if (adv[k])
            begin
                valid_next[k] = valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign in_ready  = adv[0];
    assign out_valid = valid_reg[NUM_STAGES-1];

    // Floor split: arithmetic shift gives the lattice index, low bits the fraction.
    assign ix  = lattice_t'(coord_x >>> FRAC_BITS);
    assign iy  = lattice_t'(coord_y >>> FRAC_BITS);
    assign ix1 = ix + 32'd1;
    assign iy1 = iy + 32'd1;
    assign fx  = coord_x[FRAC_BITS-1:0];
    assign fy  = coord_y[FRAC_BITS-1:0];

    vn2d_hash u_hash_a (.clk(clk), .adv(adv), .ix(ix),  .iy(iy),  .corner(ca));
    vn2d_hash u_hash_b (.clk(clk), .adv(adv), .ix(ix1), .iy(iy),  .corner(cb));
    vn2d_hash u_hash_c (.clk(clk), .adv(adv), .ix(ix),  .iy(iy1), .corner(cc));
    vn2d_hash u_hash_d (.clk(clk), .adv(adv), .ix(ix1), .iy(iy1), .corner(cd));

    vn2d_ease u_ease_x (.clk(clk), .adv(adv), .frac(fx), .eased(ux));
    vn2d_ease u_ease_y (.clk(clk), .adv(adv), .frac(fy), .eased(uy));

    vn2d_blend u_blend (
        .clk   (clk),
        .adv   (adv),
        .ca    (ca),
        .cb    (cb),
        .cc    (cc),
        .cd    (cd),
        .ux    (ux),
        .uy    (uy),
        .noise (noise_value)
    );

    // A taken output never blocks the input.
    `VN2D_ASSERT_NOW(a_ready_when_drained, clk, rst_n, out_ready, in_ready,
        "input stalled while output is being taken")

    // An accepted transfer lands in the first stage.
    `VN2D_ASSERT_NEXT(a_accept_fills_stage, clk, rst_n, in_valid && in_ready,
        valid_reg[0], "accepted transfer lost at pipeline entry")

    // A held item at the hash/blend boundary stays put.
    `VN2D_ASSERT_NEXT(a_boundary_hold, clk, rst_n,
        valid_reg[FRONT_STAGES-1] && !adv[FRONT_STAGES-1],
        valid_reg[FRONT_STAGES-1], "stalled item dropped at blend boundary")

    // Convex blends keep the result within plus or minus one.
    `VN2D_ASSERT_NOW(a_noise_range, clk, rst_n, out_valid,
        (noise_value <= 18'sd65536) && (noise_value >= -18'sd65536),
        "noise value out of range")

endmodule
